// ----- rtl/cts_pkg.sv -----
// shared widths, register indexes and request types for the column to span converter
`default_nettype none

package cts_pkg;

    localparam int COL_W     = 12;  // column field and screen_width register
    localparam int HGT_W     = 7;   // screen_height register
    localparam int ROWV_W    = 16;  // incoming row values
    localparam int START_W   = 11;  // stored span start and output columns
    localparam int ROW_OUT_W = 6;   // output row field
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b1;

    localparam logic [START_W-1:0] START_MAX = '1;

    // span start read request with the fields that ride along to the output
    typedef struct packed {
        logic                 re;
        logic [ROW_OUT_W-1:0] row;
        logic [START_W-1:0]   end_x;
        logic                 last;
    } rd_req_t;

    // span start write request
    typedef struct packed {
        logic                 we;
        logic [ROW_OUT_W-1:0] row;
        logic [START_W-1:0]   data;
    } wr_req_t;

endpackage

`default_nettype wire

// ----- rtl/cts_mem.sv -----
// per-row span start store, one read port and one write port, registered read data
`default_nettype none

module cts_mem
    import cts_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [START_W-1:0]         wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output      logic [START_W-1:0]         rdata
);

    logic [START_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cts_seq.sv -----
// row sequencer: clamps one column and walks the close and open runs
`default_nettype none

module cts_seq
    import cts_pkg::*;
#(
    parameter int ROWS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [HGT_W-1:0]     h_eff,
    input  wire logic [COL_W-1:0]     w_eff,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire logic [COL_W-1:0]     column,
    input  wire logic [ROWV_W-1:0]    prev_top,
    input  wire logic [ROWV_W-1:0]    prev_bottom,
    input  wire logic [ROWV_W-1:0]    cur_top,
    input  wire logic [ROWV_W-1:0]    cur_bottom,
    input  wire logic                 issue_ok,
    output      rd_req_t              rd_req,
    output      wr_req_t              wr_req
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int RC_W  = ROW_W + 2;   // holds -1 .. ROWS
    localparam logic signed [RC_W-1:0] ONE_RC = RC_W'(1);

    typedef enum logic [2:0] {ST_IDLE, ST_CLOSE_T, ST_CLOSE_B, ST_OPEN_T, ST_OPEN_B} state_t;

    state_t                   state_reg;
    logic signed [RC_W-1:0]   t1_reg, b1_reg, t2_reg, b2_reg;
    logic [START_W-1:0]       end_x_reg;
    logic [START_W-1:0]       s_reg;

    function automatic logic signed [RC_W-1:0] clamp_row(input logic [ROWV_W-1:0] v,
                                                        input logic [HGT_W-1:0] h);
        logic [ROW_W-1:0] r;
        if (v >= ROWV_W'(h))
        begin
            r = ROW_W'(h - HGT_W'(1));
        end
        else
        begin
            r = v[ROW_W-1:0];
        end
        return $signed({2'b00, r});
    endfunction

    logic [COL_W-1:0]       x_eff;
    logic [COL_W-1:0]       x_m1;
    logic                   cond_ct, cond_cb, cond_ot, cond_ob;
    logic signed [RC_W-1:0] t1_inc, b1_dec;
    logic                   more_after_t, more_after_b;

    assign x_eff = (column > w_eff) ? w_eff : column;
    assign x_m1  = x_eff - COL_W'(1);

    assign t1_inc = t1_reg + ONE_RC;
    assign b1_dec = b1_reg - ONE_RC;

    assign cond_ct = (t1_reg < t2_reg) && (t1_reg <= b1_reg);
    assign cond_cb = (b1_reg > b2_reg) && (b1_reg >= t1_reg);
    assign cond_ot = (t2_reg < t1_reg) && (t2_reg <= b2_reg);
    assign cond_ob = (b2_reg > b1_reg) && (b2_reg >= t2_reg);

    // does another close follow the one issued now
    assign more_after_t = ((t1_inc < t2_reg) && (t1_inc <= b1_reg)) ||
                          ((b1_reg > b2_reg) && (b1_reg >= t1_inc));
    assign more_after_b = (b1_dec > b2_reg) && (b1_dec >= t1_reg);

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        rd_req       = '0;
        wr_req       = '0;
        rd_req.end_x = end_x_reg;
        wr_req.data  = s_reg;
        unique case (state_reg)
            ST_CLOSE_T:
            begin
                rd_req.re   = cond_ct && issue_ok;
                rd_req.row  = ROW_OUT_W'(t1_reg[ROW_W-1:0]);
                rd_req.last = !more_after_t;
            end
            ST_CLOSE_B:
            begin
                rd_req.re   = cond_cb && issue_ok;
                rd_req.row  = ROW_OUT_W'(b1_reg[ROW_W-1:0]);
                rd_req.last = !more_after_b;
            end
            ST_OPEN_T:
            begin
                wr_req.we  = cond_ot;
                wr_req.row = ROW_OUT_W'(t2_reg[ROW_W-1:0]);
            end
            ST_OPEN_B:
            begin
                wr_req.we  = cond_ob;
                wr_req.row = ROW_OUT_W'(b2_reg[ROW_W-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            t1_reg    <= '0;
            b1_reg    <= '0;
            t2_reg    <= '0;
            b2_reg    <= '0;
            end_x_reg <= '0;
            s_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        t1_reg    <= clamp_row(prev_top, h_eff);
                        b1_reg    <= clamp_row(prev_bottom, h_eff);
                        t2_reg    <= clamp_row(cur_top, h_eff);
                        b2_reg    <= clamp_row(cur_bottom, h_eff);
                        end_x_reg <= x_m1[START_W-1:0];
                        s_reg     <= (x_eff > COL_W'(START_MAX)) ? START_MAX
                                                                 : x_eff[START_W-1:0];
                        state_reg <= ST_CLOSE_T;
                    end
                end
                ST_CLOSE_T:
                begin
                    if (!cond_ct)
                    begin
                        state_reg <= ST_CLOSE_B;
                    end
                    else if (issue_ok)
                    begin
                        t1_reg <= t1_inc;
                    end
                end
                ST_CLOSE_B:
                begin
                    if (!cond_cb)
                    begin
                        state_reg <= ST_OPEN_T;
                    end
                    else if (issue_ok)
                    begin
                        b1_reg <= b1_dec;
                    end
                end
                ST_OPEN_T:
                begin
                    if (!cond_ot)
                    begin
                        state_reg <= ST_OPEN_B;
                    end
                    else
                    begin
                        t2_reg <= t2_reg + ONE_RC;
                    end
                end
                ST_OPEN_B:
                begin
                    if (!cond_ob)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        b2_reg <= b2_reg - ONE_RC;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/column_to_span_converter_top.sv -----
// top level: configuration registers, span start store, sequencer and output stage
`default_nettype none

// Turns per-column floor or ceiling coverage into horizontal spans. Each input
// transfer gives a column and the previous and current top/bottom rows; every
// row that loses coverage produces one output transfer (row, start_x, end_x)
// with tlast on the last span of that column, and every row that gains
// coverage records the column as its span start. Rows are handled one per
// cycle through the span start store, which is never read and written in the
// same cycle; closes wait while the holding stage is blocked. An accepted item
// walks its close-top, close-bottom, open-top and open-bottom runs in that order.
// Reads are registered in the store and feed a one-entry holding stage in
// front of the output register. A new item is accepted only after the
// previous one has finished its walk; its spans may still sit in the output
// stage. A span start must be written before it is read; the store is not
// cleared at reset.
module column_to_span_converter_top
    import cts_pkg::*;
#(
    parameter int ROWS      = 64,
    parameter int MAX_WIDTH = 2048
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // column[11:0], prev_top[27:12], prev_bottom[43:28], cur_top[59:44], cur_bottom[75:60]
    input  wire logic [79:0]           s_tdata,
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // row[5:0], start_x[16:6], end_x[27:17]
    output      logic [31:0]           m_tdata,
    output      logic                  m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_wdata
);

    localparam int ROW_W = $clog2(ROWS);
    localparam logic [HGT_W-1:0] HMAX = HGT_W'(ROWS);
    localparam logic [COL_W-1:0] WMAX = COL_W'(MAX_WIDTH);

    logic [HGT_W-1:0] screen_height_reg;
    logic [COL_W-1:0] screen_width_reg;
    logic [HGT_W-1:0] h_eff;
    logic [COL_W-1:0] w_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg <= HGT_W'(64);
            screen_width_reg  <= COL_W'(320);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata[HGT_W-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata[COL_W-1:0];
                default:           screen_width_reg  <= screen_width_reg;
            endcase
        end
    end

    assign h_eff = (screen_height_reg == '0) ? HGT_W'(1) :
                   (screen_height_reg > HMAX) ? HMAX : screen_height_reg;
    assign w_eff = (screen_width_reg == '0) ? COL_W'(1) :
                   (screen_width_reg > WMAX) ? WMAX : screen_width_reg;

    rd_req_t             rd_req;
    wr_req_t             wr_req;
    logic                issue_ok;
    logic [START_W-1:0]  rdata;

    cts_seq #(.ROWS(ROWS)) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .h_eff       (h_eff),
        .w_eff       (w_eff),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .column      (s_tdata[11:0]),
        .prev_top    (s_tdata[27:12]),
        .prev_bottom (s_tdata[43:28]),
        .cur_top     (s_tdata[59:44]),
        .cur_bottom  (s_tdata[75:60]),
        .issue_ok    (issue_ok),
        .rd_req      (rd_req),
        .wr_req      (wr_req)
    );

    cts_mem #(.DEPTH(ROWS)) u_mem (
        .clk   (clk),
        .we    (wr_req.we),
        .waddr (wr_req.row[ROW_W-1:0]),
        .wdata (wr_req.data),
        .re    (rd_req.re),
        .raddr (rd_req.row[ROW_W-1:0]),
        .rdata (rdata)
    );

    // read in flight: its data sits in the store's read register until the output takes it
    logic                 pend_reg;
    logic [ROW_OUT_W-1:0] pend_row_reg;
    logic [START_W-1:0]   pend_end_reg;
    logic                 pend_last_reg;
    logic                 out_valid_reg;
    logic [31:0]          out_data_reg;
    logic                 out_last_reg;
    logic                 load;
    logic [START_W-1:0]   start_cap;

    assign load     = pend_reg && (!out_valid_reg || m_tready);
    assign issue_ok = !pend_reg || load;

    // saturate the stored start to the last column in use
    assign start_cap = (COL_W'(rdata) >= w_eff) ? START_W'(w_eff - COL_W'(1)) : rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_req.re)
            begin
                pend_reg <= 1'b1;
            end
            else if (load)
            begin
                pend_reg <= 1'b0;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_req.re)
        begin
            pend_row_reg  <= rd_req.row;
            pend_end_reg  <= rd_req.end_x;
            pend_last_reg <= rd_req.last;
        end
        if (load)
        begin
            out_data_reg <= {4'b0000, pend_end_reg, start_cap, pend_row_reg};
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // the sequencer uses the store as one port: a read and a write never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(rd_req.re && wr_req.we))
        else $error("span start read and write in the same cycle");

    // a read is only issued when its data has somewhere to go
    assert property (@(posedge clk) disable iff (!rst_n) rd_req.re |-> issue_ok)
        else $error("span start read issued while holding stage is blocked");

    // a blocked pending read keeps its data: no new read may overwrite it
    assert property (@(posedge clk) disable iff (!rst_n)
                     (pend_reg && !load) |=> (pend_reg && $stable(rdata)))
        else $error("pending span start lost");

    // the output only fills from a pending read
    assert property (@(posedge clk) disable iff (!rst_n)
                     (!out_valid_reg && !pend_reg) |=> !out_valid_reg)
        else $error("output valid without a pending read");

endmodule

`default_nettype wire

// ----- tb/tb_column_to_span_converter_top.sv -----
// testbench for the column to span converter: directed and random column streams checked against a span predictor
module tb_column_to_span_converter_top;
    import cts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS          = 64;
    localparam int MAX_WIDTH     = 2048;
    localparam int DRAIN_CYCLES  = ROWS + 40;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_PER_SETTING = 26;
    localparam int NUM_SETTINGS  = 8;
    localparam logic [ROWV_W-1:0] ROW_EMPTY = 16'hFFFF;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROWV_W-1:0] prev_top;
        logic [ROWV_W-1:0] prev_bottom;
        logic [ROWV_W-1:0] cur_top;
        logic [ROWV_W-1:0] cur_bottom;
    } col_item_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [START_W-1:0]   start_x;
        logic [START_W-1:0]   end_x;
        logic                 last_span;
    } span_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [79:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    // mirror of the block's registers and span start store
    logic [HGT_W-1:0]   height_reg = 7'd64;
    logic [COL_W-1:0]   width_reg = 12'd320;
    logic [START_W-1:0] row_start [0:ROWS-1];

    col_item_t pending_items [$];
    span_t     span_q [$];
    col_item_t held_item;
    span_t     want;
    int        burst_left = 0;
    int        gap_left = 0;
    logic [7:0] ready_pat = 8'hFF;
    int        pat_age = 0;
    int        idle_cycles = 0;
    int        fail_cnt = 0;

    // chain state for well-formed column sequences
    logic [ROWV_W-1:0] chain_top;
    logic [ROWV_W-1:0] chain_bottom;
    int                chain_col;

    column_to_span_converter_top #(
        .ROWS      (ROWS),
        .MAX_WIDTH (MAX_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic int eff_height();
        if (height_reg < 1)
            return 1;
        if (height_reg > ROWS)
            return ROWS;
        return int'(height_reg);
    endfunction

    function automatic int eff_width();
        if (width_reg < 1)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int clamp_row(logic [ROWV_W-1:0] v, int h);
        if (v >= h)
            return h - 1;
        return int'(v);
    endfunction

    function automatic span_t make_span(int r, int w, int x);
        span_t sp;
        sp.row       = 6'(r);
        sp.start_x   = (row_start[r] >= w) ? 11'(w - 1) : row_start[r];
        sp.end_x     = 11'(x - 1);
        sp.last_span = 1'b0;
        return sp;
    endfunction

    // walk one column: close lost rows, then record starts for gained rows
    task automatic predict_spans(input col_item_t it);
        int h;
        int w;
        int x;
        int t1;
        int b1;
        int t2;
        int b2;
        logic [START_W-1:0] s;
        span_t found [$];
        h  = eff_height();
        w  = eff_width();
        x  = int'(it.column);
        t1 = clamp_row(it.prev_top, h);
        b1 = clamp_row(it.prev_bottom, h);
        t2 = clamp_row(it.cur_top, h);
        b2 = clamp_row(it.cur_bottom, h);
        if (x - 1 >= w)
            x = w;
        while (t1 < t2 && t1 <= b1)
        begin
            found.push_back(make_span(t1, w, x));
            t1++;
        end
        while (b1 > b2 && b1 >= t1)
        begin
            found.push_back(make_span(b1, w, x));
            b1--;
        end
        s = (x > int'(START_MAX)) ? START_MAX : 11'(x);
        while (t2 < t1 && t2 <= b2)
        begin
            row_start[t2] = s;
            t2++;
        end
        while (b2 > b1 && b2 >= t2)
        begin
            row_start[b2] = s;
            b2--;
        end
        if (found.size() > 0)
            found[found.size() - 1].last_span = 1'b1;
        foreach (found[i])
            span_q.push_back(found[i]);
    endtask

    task automatic push_item(input int col, input int pt, input int pb, input int ct,
                             input int cb);
        col_item_t it;
        it.column      = 12'(col);
        it.prev_top    = 16'(pt);
        it.prev_bottom = 16'(pb);
        it.cur_top     = 16'(ct);
        it.cur_bottom  = 16'(cb);
        pending_items.push_back(it);
    endtask

    function automatic logic [ROWV_W-1:0] pick_edge(int hs);
        case ($urandom_range(0, 11))
            0: return ROW_EMPTY;
            1: return 16'($urandom_range(0, 65535));
            2: return 16'(hs);
            3: return 16'(hs - 1);
            4: return 16'd0;
            default: return 16'($urandom_range(0, hs - 1));
        endcase
    endfunction

    // mostly chained columns where prev is the last cur, with some noise and broken links
    task automatic add_random_items(input int count);
        int hs;
        int k;
        int kind;
        logic [ROWV_W-1:0] top;
        logic [ROWV_W-1:0] bot;
        logic [ROWV_W-1:0] tmp;
        col_item_t it;
        hs = eff_height();
        for (k = 0; k < count; k++)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                it.column      = 12'($urandom_range(0, 4095));
                it.prev_top    = 16'($urandom_range(0, 65535));
                it.prev_bottom = 16'($urandom_range(0, 65535));
                it.cur_top     = 16'($urandom_range(0, 65535));
                it.cur_bottom  = 16'($urandom_range(0, 65535));
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    top = ROW_EMPTY;
                    bot = 16'd0;
                end
                else
                begin
                    top = pick_edge(hs);
                    bot = pick_edge(hs);
                    if (top > bot && $urandom_range(0, 3) != 0)
                    begin
                        tmp = top;
                        top = bot;
                        bot = tmp;
                    end
                end
                case ($urandom_range(0, 19))
                    0: chain_col = $urandom_range(0, 4095);
                    1: chain_col = 0;
                    2, 3: chain_col = $urandom_range(0, eff_width());
                    default: chain_col = (chain_col + 1) % 4096;
                endcase
                it.column = 12'(chain_col);
                if (kind == 1)
                begin
                    it.prev_top    = pick_edge(hs);
                    it.prev_bottom = pick_edge(hs);
                end
                else
                begin
                    it.prev_top    = chain_top;
                    it.prev_bottom = chain_bottom;
                end
                it.cur_top    = top;
                it.cur_bottom = bot;
                chain_top     = top;
                chain_bottom  = bot;
            end
            pending_items.push_back(it);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DAT_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SCREEN_HEIGHT)
            height_reg = 7'(value);
        else
            width_reg = 12'(value);
    endtask

    // nothing queued, nothing in flight, then let a walk with no spans finish
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || span_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // column sender: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_spans(held_item);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    held_item = pending_items.pop_front();
                    s_tdata <= {4'b0, held_item.cur_bottom, held_item.cur_top,
                                held_item.prev_bottom, held_item.prev_top, held_item.column};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(20, 90);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // span receiver: checks each transfer, stalls on a rotating ready pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            ready_pat = 8'hFF;
            pat_age = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (span_q.size() == 0)
                begin
                    $error("span transfer with none expected: row %0d start_x %0d end_x %0d",
                           m_tdata[5:0], m_tdata[16:6], m_tdata[27:17]);
                    fail_cnt++;
                end
                else
                begin
                    want = span_q.pop_front();
                    if (m_tdata[5:0] !== want.row)
                    begin
                        $error("row: expected %0d, got %0d", want.row, m_tdata[5:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[16:6] !== want.start_x)
                    begin
                        $error("start_x: expected %0d, got %0d", want.start_x, m_tdata[16:6]);
                        fail_cnt++;
                    end
                    if (m_tdata[27:17] !== want.end_x)
                    begin
                        $error("end_x: expected %0d, got %0d", want.end_x, m_tdata[27:17]);
                        fail_cnt++;
                    end
                    if (m_tlast !== want.last_span)
                    begin
                        $error("last_span: expected %0d, got %0d", want.last_span, m_tlast);
                        fail_cnt++;
                    end
                end
            end
            pat_age++;
            if (pat_age == 40)
            begin
                pat_age = 0;
                case ($urandom_range(0, 4))
                    0, 1: ready_pat = 8'hFF;
                    2: ready_pat = 8'b0000_0001;
                    3: ready_pat = 8'b1010_1010;
                    default: ready_pat = 8'($urandom_range(1, 255));
                endcase
            end
            m_tready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[7:1]};
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int p;
        int setting_h [NUM_SETTINGS];
        int setting_w [NUM_SETTINGS];
        setting_h = '{1, 64, 0, 127, 100, 8, 33, 64};
        setting_w = '{1, 2048, 0, 4095, 2000, 16, 640, 320};
        chain_top = ROW_EMPTY;
        chain_bottom = 16'd0;
        chain_col = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // open every row first so no span start is read before it is written
        push_item(0, ROW_EMPTY, 0, 0, 63);
        push_item(1, 0, 63, 10, 50);
        // column zero wraps end_x
        push_item(0, 10, 50, 20, 40);
        push_item(5, 20, 40, 0, 63);
        // nothing changes, no span
        push_item(7, 0, 63, 0, 63);
        // column beyond width, every row closes
        push_item(4095, 0, 63, ROW_EMPTY, 0);
        // start beyond width, capped on read
        push_item(3000, ROW_EMPTY, 0, 0, 63);
        push_item(100, 0, 63, 1000, 65534);
        push_item(2048, 63, 63, ROW_EMPTY, 0);
        // inverted previous range
        push_item(12, 40, 10, 5, 60);
        push_item(13, 5, 60, 65535, 65535);
        push_item(14, 63, 63, 0, 0);
        wait_idle();

        for (p = 0; p < NUM_SETTINGS; p++)
        begin
            write_reg(REG_SCREEN_HEIGHT, setting_h[p]);
            write_reg(REG_SCREEN_WIDTH, setting_w[p]);
            chain_top = ROW_EMPTY;
            chain_bottom = 16'd0;
            if (p == 3)
            begin
                // start saturates in the store, then reads back at the top of the width
                push_item(4095, ROW_EMPTY, 0, 0, 63);
                push_item(2048, 0, 63, 30, 30);
            end
            add_random_items(RANDOM_PER_SETTING);
            wait_idle();
        end

        if (fail_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cts_pkg.sv
rtl/cts_mem.sv
rtl/cts_seq.sv
rtl/column_to_span_converter_top.sv
tb/tb_column_to_span_converter_top.sv
